/* design/pmsa_pkg.sv */
// Shared widths, register indexes and reset values for the power meter accumulator.
package pmsa_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP_OFS  = 2'd2;

	// Register widths and reset values.
	localparam int PF_W  = 16;
	localparam int OFS_W = 14;

	localparam logic [PF_W-1:0]  PHASE_RST = 16'd32768;
	localparam logic [OFS_W-1:0] OFS_RST   = 14'd8192;

	// Result field widths.
	localparam int VOLT_W = 16;
	localparam int AMP_W  = 15;
	localparam int SQ_W   = 63;
	localparam int POW_W  = 64;

	localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
	localparam logic [POW_W-1:0] POW_MAX = {1'b0, {(POW_W-1){1'b1}}};
	localparam logic [POW_W-1:0] POW_MIN = {1'b1, {(POW_W-1){1'b0}}};

	// Digit-serial multiply: two bits per cycle over a 16-bit multiplier.
	localparam int DIGIT_W = 2;
	localparam int DIGITS  = PF_W / DIGIT_W;
	localparam int CNT_W   = $clog2(DIGITS);

	// Product width for the squares and the power term.
	localparam int PRD_W = 32;

	// Interpolation product carries 15 fractional bits; 4 are kept.
	localparam int FRAC_DROP  = 11;
	localparam int ROUND_BIAS = 1024;

endpackage

/* design/power_meter_sample_accumulator_unit.sv */
// Power meter sample accumulator: phase correction, offset removal and saturating sums.
// Each accepted item passes through a digit-serial interpolation pass, a setup step, a
// digit-serial pass that forms the three products, and an accumulate step that waits while
// a held result is stalled; the block takes no new item until that step commits.
// Input is taken only when the datapath is idle; a finished result waits in the output stage.
// Reset (asynchronous, active low) clears the sums, the flag and the previous voltage,
// and loads the phase fraction with 1.0 and both offsets with 512 counts.
module power_meter_sample_accumulator_unit #(
	parameter int ADC_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes.
	input  logic                              cfg_wen,
	input  logic [pmsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Sample input.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ADC_BITS-1:0]               raw_volt,
	input  logic [ADC_BITS-1:0]               raw_amp,
	input  logic                              clear_sums,
	// Result output.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pmsa_pkg::VOLT_W-1:0] volt_value,
	output logic signed [pmsa_pkg::AMP_W-1:0]  amp_value,
	output logic [pmsa_pkg::SQ_W-1:0]         volt_square_sum,
	output logic [pmsa_pkg::SQ_W-1:0]         amp_square_sum,
	output logic signed [pmsa_pkg::POW_W-1:0] power_sum,
	output logic                              sum_saturated
);
	import pmsa_pkg::*;

	// Datapath widths that follow from the ADC width.
	localparam int DW = ADC_BITS + 1;
	localparam int PW = ADC_BITS + 19;
	localparam int VW = PW + 1;
	localparam int AW = ADC_BITS + 16;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INTERP = 3'd1;
	localparam logic [2:0] ST_CALC   = 3'd2;
	localparam logic [2:0] ST_PROD   = 3'd3;
	localparam logic [2:0] ST_ACC    = 3'd4;

	localparam logic signed [VW-1:0] V_MIN = VW'(-32'sd32768);
	localparam logic signed [VW-1:0] V_MAX = VW'(32'sd32767);
	localparam logic signed [AW-1:0] A_MIN = AW'(-32'sd16384);
	localparam logic signed [AW-1:0] A_MAX = AW'(32'sd16383);

	// One signed-digit partial product; the top digit of a two's complement
	// multiplier carries negative weight on its upper bit.
	function automatic logic signed [PRD_W-1:0] sd_term(
		input logic [DIGIT_W-1:0]      d,
		input logic                    top,
		input logic signed [PRD_W-1:0] m
	);
		logic signed [PRD_W-1:0] t;
		t = d[0] ? m : '0;
		if (d[1]) begin
			t = top ? (t - (m <<< 1)) : (t + (m <<< 1));
		end
		return t;
	endfunction

	// Control and state registers.
	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic [PF_W-1:0]         phase_q;
	logic [OFS_W-1:0]        volt_ofs_q;
	logic [OFS_W-1:0]        amp_ofs_q;
	logic [ADC_BITS-1:0]     prev_q;
	logic [SQ_W-1:0]         vsq_acc_q;
	logic [SQ_W-1:0]         asq_acc_q;
	logic [POW_W-1:0]        pow_acc_q;
	logic                    sat_q;

	// Payload registers.
	logic [ADC_BITS-1:0]     cur_volt_q;
	logic [ADC_BITS-1:0]     cur_amp_q;
	logic                    clr_q;
	logic [PF_W-1:0]         pf_sh_q;
	logic signed [PW-1:0]    mcand_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [VOLT_W-1:0] v_q;
	logic signed [AMP_W-1:0]  a_q;
	logic [VOLT_W-1:0]       v_sh_q;
	logic [VOLT_W-1:0]       a_sh_q;
	logic signed [PRD_W-1:0] mv_q;
	logic signed [PRD_W-1:0] ma_q;
	logic signed [PRD_W-1:0] pvv_q;
	logic signed [PRD_W-1:0] pav_q;
	logic signed [PRD_W-1:0] paa_q;
	logic signed [VOLT_W-1:0] volt_out_q;
	logic signed [AMP_W-1:0]  amp_out_q;

	logic                    accept;
	logic                    last;
	logic                    commit;
	logic signed [DW-1:0]    diff;
	logic signed [PW-1:0]    interp_term;
	logic signed [PW-1:0]    q_shift;
	logic signed [VW-1:0]    v_base;
	logic signed [VW-1:0]    v_step;
	logic signed [VW-1:0]    v_ofs;
	logic signed [VW-1:0]    v_full;
	logic signed [AW-1:0]    a_pos;
	logic signed [AW-1:0]    a_ofs;
	logic signed [AW-1:0]    a_full;
	logic signed [VOLT_W-1:0] v_sat;
	logic signed [AMP_W-1:0]  a_sat;
	logic [SQ_W-1:0]         vsq_base;
	logic [SQ_W-1:0]         asq_base;
	logic [POW_W-1:0]        pow_base;
	logic [SQ_W:0]           vsq_sum;
	logic [SQ_W:0]           asq_sum;
	logic [POW_W:0]          pow_sum;
	logic                    vsq_ovf;
	logic                    asq_ovf;
	logic                    pow_ovf;
	logic [SQ_W-1:0]         vsq_next;
	logic [SQ_W-1:0]         asq_next;
	logic [POW_W-1:0]        pow_next;

	// Handshake and sequencing conditions.
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign last     = (cnt_q == CNT_W'(DIGITS - 1));
	assign commit   = (state_q == ST_ACC) && (!out_valid_q || !out_stall);

	// Step from the previous to the present raw voltage.
	assign diff = $signed({1'b0, raw_volt}) - $signed({1'b0, prev_q});

	// Interpolation partial product for the current unsigned fraction digit.
	always_comb begin
		interp_term = pf_sh_q[0] ? mcand_q : '0;
		if (pf_sh_q[1]) begin
			interp_term = interp_term + (mcand_q <<< 1);
		end
	end

	// Corrected voltage and current with clamping.
	always_comb begin
		q_shift = prod_q >>> FRAC_DROP;
		v_base  = VW'({prev_q, 4'b0000});
		v_step  = {q_shift[PW-1], q_shift};
		v_ofs   = VW'(volt_ofs_q);
		v_full  = v_base + v_step - v_ofs;
		if (v_full < V_MIN) begin
			v_sat = V_MIN[VOLT_W-1:0];
		end else if (v_full > V_MAX) begin
			v_sat = V_MAX[VOLT_W-1:0];
		end else begin
			v_sat = v_full[VOLT_W-1:0];
		end
		a_pos  = AW'({cur_amp_q, 4'b0000});
		a_ofs  = AW'(amp_ofs_q);
		a_full = a_pos - a_ofs;
		if (a_full < A_MIN) begin
			a_sat = A_MIN[AMP_W-1:0];
		end else if (a_full > A_MAX) begin
			a_sat = A_MAX[AMP_W-1:0];
		end else begin
			a_sat = a_full[AMP_W-1:0];
		end
	end

	// Saturating accumulation, after an optional clear.
	always_comb begin
		vsq_base = clr_q ? '0 : vsq_acc_q;
		asq_base = clr_q ? '0 : asq_acc_q;
		pow_base = clr_q ? '0 : pow_acc_q;
		vsq_sum  = {1'b0, vsq_base} + (SQ_W+1)'(unsigned'(pvv_q));
		asq_sum  = {1'b0, asq_base} + (SQ_W+1)'(unsigned'(paa_q));
		pow_sum  = {pow_base[POW_W-1], pow_base}
			+ {{(POW_W-PRD_W+1){pav_q[PRD_W-1]}}, pav_q};
		vsq_ovf  = vsq_sum[SQ_W];
		asq_ovf  = asq_sum[SQ_W];
		pow_ovf  = pow_sum[POW_W] != pow_sum[POW_W-1];
		vsq_next = vsq_ovf ? SQ_MAX : vsq_sum[SQ_W-1:0];
		asq_next = asq_ovf ? SQ_MAX : asq_sum[SQ_W-1:0];
		if (pow_ovf) begin
			pow_next = pow_sum[POW_W] ? POW_MIN : POW_MAX;
		end else begin
			pow_next = pow_sum[POW_W-1:0];
		end
	end

	// Sequencer, configuration registers, accumulators and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= PHASE_RST;
			volt_ofs_q  <= OFS_RST;
			amp_ofs_q   <= OFS_RST;
			prev_q      <= '0;
			vsq_acc_q   <= '0;
			asq_acc_q   <= '0;
			pow_acc_q   <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_PHASE:    phase_q    <= cfg_data[PF_W-1:0];
					REG_VOLT_OFS: volt_ofs_q <= cfg_data[OFS_W-1:0];
					REG_AMP_OFS:  amp_ofs_q  <= cfg_data[OFS_W-1:0];
					default: ;
				endcase
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_INTERP;
					end
				end
				ST_INTERP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					cnt_q   <= '0;
					prev_q  <= cur_volt_q;
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (commit) begin
						vsq_acc_q <= vsq_next;
						asq_acc_q <= asq_next;
						pow_acc_q <= pow_next;
						sat_q     <= (sat_q && !clr_q) || vsq_ovf || asq_ovf || pow_ovf;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Digit-serial datapath: multiplier digits shift out, multiplicands shift up.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_volt_q <= raw_volt;
			cur_amp_q  <= raw_amp;
			clr_q      <= clear_sums;
			pf_sh_q    <= phase_q;
			mcand_q    <= {{(PW-DW){diff[DW-1]}}, diff};
			prod_q     <= PW'(ROUND_BIAS);
		end
		if (state_q == ST_INTERP) begin
			prod_q  <= prod_q + interp_term;
			mcand_q <= mcand_q <<< DIGIT_W;
			pf_sh_q <= pf_sh_q >> DIGIT_W;
		end
		if (state_q == ST_CALC) begin
			v_q    <= v_sat;
			a_q    <= a_sat;
			v_sh_q <= v_sat;
			a_sh_q <= {a_sat[AMP_W-1], a_sat};
			mv_q   <= {{(PRD_W-VOLT_W){v_sat[VOLT_W-1]}}, v_sat};
			ma_q   <= {{(PRD_W-AMP_W){a_sat[AMP_W-1]}}, a_sat};
			pvv_q  <= '0;
			pav_q  <= '0;
			paa_q  <= '0;
		end
		if (state_q == ST_PROD) begin
			pvv_q  <= pvv_q + sd_term(v_sh_q[DIGIT_W-1:0], last, mv_q);
			pav_q  <= pav_q + sd_term(v_sh_q[DIGIT_W-1:0], last, ma_q);
			paa_q  <= paa_q + sd_term(a_sh_q[DIGIT_W-1:0], last, ma_q);
			mv_q   <= mv_q <<< DIGIT_W;
			ma_q   <= ma_q <<< DIGIT_W;
			v_sh_q <= v_sh_q >> DIGIT_W;
			a_sh_q <= a_sh_q >> DIGIT_W;
		end
		if (commit) begin
			volt_out_q <= v_q;
			amp_out_q  <= a_q;
		end
	end

	// The sums only change on commit, so the accumulators drive the result directly.
	assign out_valid       = out_valid_q;
	assign volt_value      = volt_out_q;
	assign amp_value       = amp_out_q;
	assign volt_square_sum = vsq_acc_q;
	assign amp_square_sum  = asq_acc_q;
	assign power_sum       = pow_acc_q;
	assign sum_saturated   = sat_q;

endmodule

/* design/pmsa_checker.sv */
// Port-level checks for the power meter accumulator, bound to the top level.
module pmsa_checker #(
	parameter int ADC_BITS = 10
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [ADC_BITS-1:0]               raw_volt,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [pmsa_pkg::SQ_W-1:0]         volt_square_sum,
	input logic signed [pmsa_pkg::POW_W-1:0] power_sum
);
	import pmsa_pkg::*;

	// An accepted item keeps the datapath busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an item was accepted");

	// A stalled input item stays valid and keeps its voltage sample.
	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(raw_volt)))
		else $error("stalled input item changed");

	// A new result only appears while the datapath was busy.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	// A waiting result keeps its sums.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(volt_square_sum)
			&& $stable(power_sum)))
		else $error("stalled result changed");

endmodule

bind power_meter_sample_accumulator_unit pmsa_checker #(.ADC_BITS(ADC_BITS)) u_pmsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.raw_volt        (raw_volt),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.volt_square_sum (volt_square_sum),
	.power_sum       (power_sum)
);

/* tb/testbench.sv */
// Self-checking testbench for the power meter sample accumulator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pmsa_pkg::*;

	localparam int ADC_W = 10;

	// Index past the last register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic [63:0] SQUARE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint POWER_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint POWER_LO = -POWER_HI - 64'sd1;

	typedef struct packed {
		logic [ADC_W-1:0] volt;
		logic [ADC_W-1:0] amp;
		logic             clr;
	} sample_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0] volt;
		logic signed [AMP_W-1:0]  amp;
		logic [SQ_W-1:0]          volt_sq;
		logic [SQ_W-1:0]          amp_sq;
		logic signed [POW_W-1:0]  power;
		logic                     sat;
	} meter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic             in_valid = 1'b0;
	logic             in_stall;
	sample_t          cur_sample = '0;
	logic [ADC_W-1:0] raw_volt;
	logic [ADC_W-1:0] raw_amp;
	logic             clear_sums;

	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [VOLT_W-1:0] volt_value;
	logic signed [AMP_W-1:0]  amp_value;
	logic [SQ_W-1:0]          volt_square_sum;
	logic [SQ_W-1:0]          amp_square_sum;
	logic signed [POW_W-1:0]  power_sum;
	logic                     sum_saturated;

	assign raw_volt   = cur_sample.volt;
	assign raw_amp    = cur_sample.amp;
	assign clear_sums = cur_sample.clr;

	// Shadow registers and accumulator state of the predictor.
	logic [PF_W-1:0]  phase_q = PHASE_RST;
	logic [OFS_W-1:0] volt_ofs_q = OFS_RST;
	logic [OFS_W-1:0] amp_ofs_q = OFS_RST;
	logic [ADC_W-1:0] last_volt = '0;
	logic [63:0]      volt_sq_total = '0;
	logic [63:0]      amp_sq_total = '0;
	longint           power_total = 0;
	logic             sat_seen = 1'b0;

	sample_t       pending_samples[$];
	meter_result_t expected_results[$];

	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned bad_results = 0;

	power_meter_sample_accumulator_unit #(
		.ADC_BITS(ADC_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_volt(raw_volt),
		.raw_amp(raw_amp),
		.clear_sums(clear_sums),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.volt_value(volt_value),
		.amp_value(amp_value),
		.volt_square_sum(volt_square_sum),
		.amp_square_sum(amp_square_sum),
		.power_sum(power_sum),
		.sum_saturated(sum_saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Saturating add for the two square sums.
	function automatic logic [63:0] add_square(logic [63:0] acc, logic [63:0] x);
		if (acc > SQUARE_LIMIT || x > SQUARE_LIMIT - acc) begin
			sat_seen = 1'b1;
			return SQUARE_LIMIT;
		end
		return acc + x;
	endfunction

	// Phase correction, offset removal and accumulation of one sample.
	function automatic meter_result_t accumulate_sample(sample_t s);
		longint        prev;
		longint        prod;
		longint        v;
		longint        a;
		longint        p;
		meter_result_t r;
		prev = longint'(last_volt);
		prod = longint'(phase_q) * (longint'(s.volt) - prev) + ROUND_BIAS;
		v = prev * 16 + (prod >>> FRAC_DROP) - longint'(volt_ofs_q);
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		a = longint'(s.amp) * 16 - longint'(amp_ofs_q);
		if (a < -16384) a = -16384;
		if (a > 16383) a = 16383;
		last_volt = s.volt;

		if (s.clr) begin
			volt_sq_total = '0;
			amp_sq_total = '0;
			power_total = 0;
			sat_seen = 1'b0;
		end

		volt_sq_total = add_square(volt_sq_total, 64'(v * v));
		amp_sq_total = add_square(amp_sq_total, 64'(a * a));

		// Power sum saturates at the signed 64-bit limits.
		p = v * a;
		if (p > 0 && power_total > POWER_HI - p) begin
			sat_seen = 1'b1;
			power_total = POWER_HI;
		end else if (p < 0 && power_total < POWER_LO - p) begin
			sat_seen = 1'b1;
			power_total = POWER_LO;
		end else begin
			power_total = power_total + p;
		end

		r.volt = v[VOLT_W-1:0];
		r.amp = a[AMP_W-1:0];
		r.volt_sq = volt_sq_total[SQ_W-1:0];
		r.amp_sq = amp_sq_total[SQ_W-1:0];
		r.power = power_total;
		r.sat = sat_seen;
		return r;
	endfunction

	// Sample source: predicts each item as it is accepted and presents the next one.
	always @(posedge clk) begin : drive_samples
		sample_t nxt;
		logic    take;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			take = !in_valid || !in_stall;
			if (in_valid && !in_stall)
				expected_results.push_back(accumulate_sample(cur_sample));
			if (take) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = pending_samples.pop_front();
					cur_sample <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: random stalls and comparison against the oldest expectation.
	always @(posedge clk) begin : check_results
		meter_result_t got;
		meter_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {volt_value, amp_value, volt_square_sum, amp_square_sum,
					power_sum, sum_saturated};
				if (expected_results.size() == 0) begin
					if (bad_results < 10)
						$display("unexpected result: volt %0d amp %0d", got.volt, got.amp);
					bad_results++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (bad_results < 10) begin
							$display("mismatch exp/got: volt %0d/%0d amp %0d/%0d sat %0b/%0b",
								want.volt, got.volt, want.amp, got.amp, want.sat, got.sat);
							$display("  vsq %0d/%0d asq %0d/%0d pow %0d/%0d",
								want.volt_sq, got.volt_sq, want.amp_sq, got.amp_sq,
								want.power, got.power);
						end
						bad_results++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic add_sample(int unsigned v, int unsigned a, bit c);
		sample_t s;
		s.volt = ADC_W'(v);
		s.amp = ADC_W'(a);
		s.clr = c;
		pending_samples.push_back(s);
	endtask

	// Waits until every queued item has gone through and every result has come back.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	// One register write; the shadow copy follows at the edge the block takes it.
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_PHASE:    phase_q = data;
			REG_VOLT_OFS: volt_ofs_q = data[OFS_W-1:0];
			REG_AMP_OFS:  amp_ofs_q = data[OFS_W-1:0];
			default:      ;
		endcase
	endtask

	// Register value: the extremes a good share of the time, otherwise random.
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return CFG_DATA_W'($urandom());
		endcase
	endfunction

	// ADC code: rails, a small step from the last level, or full-range noise.
	function automatic logic [ADC_W-1:0] pick_raw(logic [ADC_W-1:0] near);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return '0;
		if (sel < 16)
			return '1;
		if (sel < 60)
			return near + ADC_W'($urandom_range(63)) - ADC_W'(32);
		return ADC_W'($urandom());
	endfunction

	// Measurement windows: each opens with a clear, then a run of wave-like samples with occasional further clears.
	task automatic random_samples(int unsigned count);
		sample_t          s;
		int unsigned      left;
		int unsigned      burst;
		int unsigned      k;
		logic [ADC_W-1:0] volt_level;
		logic [ADC_W-1:0] amp_level;
		left = count;
		volt_level = ADC_W'($urandom());
		amp_level = ADC_W'($urandom());
		while (left > 0) begin
			burst = $urandom_range(40, 8);
			if (burst > left)
				burst = left;
			for (k = 0; k < burst; k++) begin
				s.volt = pick_raw(volt_level);
				s.amp = pick_raw(amp_level);
				s.clr = (k == 0) || ($urandom_range(31) == 0);
				volt_level = s.volt;
				amp_level = s.amp;
				pending_samples.push_back(s);
			end
			left -= burst;
		end
	endtask

	initial begin : run_test
		int unsigned ph;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings; the first item interpolates from a zero previous voltage.
		add_sample(0, 0, 0);
		add_sample(1023, 1023, 0);
		add_sample(0, 0, 0);
		add_sample(1023, 0, 1);
		add_sample(512, 512, 0);
		add_sample(1, 1023, 0);
		settle();

		// Zero phase fraction, so the previous voltage is used, and no offsets.
		set_reg(REG_PHASE, '0);
		set_reg(REG_VOLT_OFS, '0);
		set_reg(REG_AMP_OFS, '0);
		add_sample(1023, 1023, 0);
		add_sample(0, 0, 0);
		settle();

		// Largest fraction and largest offsets; the offset writes carry extra high bits.
		set_reg(REG_PHASE, '1);
		set_reg(REG_VOLT_OFS, '1);
		set_reg(REG_AMP_OFS, '1);
		add_sample(1023, 1023, 0);
		add_sample(0, 0, 0);
		add_sample(0, 0, 1);
		add_sample(1023, 0, 0);
		settle();

		// Exact half steps round toward plus infinity in both directions.
		set_reg(REG_PHASE, 16'd1024);
		set_reg(REG_VOLT_OFS, 16'd8192);
		set_reg(REG_AMP_OFS, 16'd8192);
		add_sample(100, 0, 0);
		add_sample(101, 0, 0);
		add_sample(100, 0, 0);
		settle();

		// A write past the last register must change nothing.
		set_reg(REG_SPARE, 16'h1234);
		add_sample(513, 513, 0);
		add_sample(1023, 0, 1);
		settle();

		// Random windows under each idling pattern, with fresh settings each time.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 84; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 84; end
				default: begin send_gap_pct = 11; stall_pct = 11; end
			endcase
			set_reg(REG_PHASE, pick_reg_value());
			set_reg(REG_VOLT_OFS, pick_reg_value());
			set_reg(REG_AMP_OFS, pick_reg_value());
			random_samples(200);
			settle();
		end

		repeat (40) @(posedge clk);
		if (bad_results == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#(10_000_000);
		$display("testbench: FAIL");
		$finish;
	end

endmodule

/* power_meter_sample_accumulator_unit.f */
design/pmsa_pkg.sv
design/power_meter_sample_accumulator_unit.sv
design/pmsa_checker.sv
tb/testbench.sv
